FILE: hw/rtl/ein_pkg.sv
// shared widths, register codes and the pipeline item type for the edge index decoder
package ein_pkg;

    localparam int NODE_BITS = 16;
    localparam int CNT_BITS  = NODE_BITS + 1;
    localparam int IDX_BITS  = 2 * NODE_BITS + 1;
    localparam int TRI_BITS  = 2 * NODE_BITS + 2;
    localparam int PROD_BITS = 2 * CNT_BITS + 1;
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_NODE_COUNT    = 2'd0,
        CFG_DIRECTED_MODE = 2'd1,
        CFG_ALLOW_LOOPS   = 2'd2
    } t_cfg_reg;

    // one request as it moves through the bit stages
    typedef struct packed {
        logic [IDX_BITS-1:0] s;
        logic                bad;
        logic [IDX_BITS-1:0] rem;
        logic [CNT_BITS-1:0] quo;
        logic [CNT_BITS-1:0] row;
        logic [TRI_BITS-1:0] tsum;
    } t_item;

    // static settings seen by the datapath
    typedef struct packed {
        logic                 directed;
        logic                 loops;
        logic [CNT_BITS-1:0]  div;
        logic [NODE_BITS-1:0] nm1;
        logic [PROD_BITS-1:0] maxe;
    } t_setup;

endpackage

FILE: hw/rtl/ein_front.sv
// entry stage: range check and seeding of the divide and row search
module ein_front
    import ein_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [IDX_BITS-1:0] i_edge_index,
    input  t_setup              i_setup,
    input  logic                i_ready,
    output logic                o_ready,
    output logic                o_valid,
    output t_item               o_item
);

    logic  r_v;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_item  = r_item;

    // seed the item
    always_comb begin
        n_item.s    = i_edge_index;
        n_item.bad  = (i_edge_index == '0) ||
                      ({{(PROD_BITS-IDX_BITS){1'b0}}, i_edge_index} > i_setup.maxe);
        n_item.rem  = i_edge_index - IDX_BITS'(1);
        n_item.quo  = '0;
        n_item.row  = '0;
        n_item.tsum = '0;
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: hw/rtl/ein_core.sv
// one stage per quotient bit: restoring divide and triangular row search side by side
module ein_core
    import ein_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_item               i_item,
    input  logic [CNT_BITS-1:0] i_div,
    input  logic                i_ready,
    output logic                o_ready,
    output logic                o_valid,
    output t_item               o_item
);

    logic  r_v    [CNT_BITS];
    t_item r_item [CNT_BITS];
    logic  rdy    [CNT_BITS+1];

    assign rdy[CNT_BITS] = i_ready;
    assign o_ready = rdy[0];
    assign o_valid = r_v[CNT_BITS-1];
    assign o_item  = r_item[CNT_BITS-1];

    for (genvar j = 0; j < CNT_BITS; j++) begin : g_stage
        localparam int K = CNT_BITS - 1 - j;
        localparam logic [TRI_BITS:0] TK =
            (TRI_BITS+1)'((((64'd1 << K) * ((64'd1 << K) + 64'd1))) / 64'd2);

        logic          src_v;
        t_item         src;
        t_item         n_item;
        logic [TRI_BITS-1:0] dk;
        logic [TRI_BITS:0]   tc;

        assign src_v = (j == 0) ? i_valid : r_v[(j == 0) ? 0 : j-1];
        assign src   = (j == 0) ? i_item  : r_item[(j == 0) ? 0 : j-1];
        assign rdy[j] = !r_v[j] || rdy[j+1];

        // test one quotient bit and one row bit
        always_comb begin
            n_item = src;
            dk = TRI_BITS'(i_div) << K;
            if ({1'b0, src.rem} >= dk) begin
                n_item.rem    = src.rem - dk[IDX_BITS-1:0];
                n_item.quo[K] = 1'b1;
            end
            tc = {1'b0, src.tsum} + ((TRI_BITS+1)'(src.row) << K) + TK;
            if (tc < {2'b0, src.s}) begin
                n_item.row[K] = 1'b1;
                n_item.tsum   = tc[TRI_BITS-1:0];
            end
        end

        // stage valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (rdy[j]) begin
                r_v[j] <= src_v;
            end
        end

        // stage payload
        always_ff @(posedge i_clk) begin
            if (rdy[j] && src_v) begin
                r_item[j] <= n_item;
            end
        end
    end

endmodule

FILE: hw/rtl/ein_back.sv
// output stage: picks the vertex pair for the mode and holds the result
module ein_back
    import ein_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_item                i_item,
    input  t_setup               i_setup,
    input  logic                 i_stall,
    output logic                 o_ready,
    output logic                 o_valid,
    output logic [NODE_BITS-1:0] o_from_node,
    output logic [NODE_BITS-1:0] o_to_node,
    output logic                 o_index_out_of_range
);

    logic                 r_v;
    logic [NODE_BITS-1:0] r_from;
    logic [NODE_BITS-1:0] r_to;
    logic                 r_oor;
    logic [NODE_BITS-1:0] n_from;
    logic [NODE_BITS-1:0] n_to;
    logic [CNT_BITS-1:0]  rem_inc;
    logic [CNT_BITS-1:0]  to_mod;
    logic [IDX_BITS-1:0]  tri_off;

    assign o_ready = !r_v || !i_stall;
    assign o_valid = r_v;
    assign o_from_node = r_from;
    assign o_to_node   = r_to;
    assign o_index_out_of_range = r_oor;

    // pair selection by mode
    always_comb begin
        rem_inc = i_item.rem[CNT_BITS-1:0] + CNT_BITS'(1);
        to_mod  = (rem_inc == i_setup.div) ? '0 : rem_inc;
        tri_off = i_item.s - i_item.tsum[IDX_BITS-1:0] - IDX_BITS'(1);
        if (i_setup.directed && i_setup.loops) begin
            n_from = i_item.quo[NODE_BITS-1:0];
            n_to   = i_item.rem[NODE_BITS-1:0];
        end else if (i_setup.directed) begin
            n_from = i_item.quo[NODE_BITS-1:0];
            n_to   = (i_item.quo == to_mod) ? i_setup.nm1 : to_mod[NODE_BITS-1:0];
        end else if (i_setup.loops) begin
            n_from = i_item.row[NODE_BITS-1:0];
            n_to   = tri_off[NODE_BITS-1:0];
        end else begin
            n_from = i_item.row[NODE_BITS-1:0] + NODE_BITS'(1);
            n_to   = tri_off[NODE_BITS-1:0];
        end
        if (i_item.bad) begin
            n_from = '0;
            n_to   = '0;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_from <= n_from;
            r_to   <= n_to;
            r_oor  <= i_item.bad;
        end
    end

endmodule

FILE: hw/rtl/edge_index_to_node_pair.sv
// A request passes through the entry stage, 17 bit stages and the output stage, each registered.
// Throughput: one request per cycle while the receiver does not stall; each of the 17 bit
// stages resolves one quotient bit and one triangular row bit with a single add and compare.
// Bubbles collapse, so a request is taken while a result waits at the output.
// Reset (synchronous, active low) empties the pipeline and sets node_count 2,
// undirected, no loops.
module edge_index_to_node_pair
    import ein_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CNT_BITS-1:0]     i_cfg_data,
    input  logic                    i_valid,
    input  logic [IDX_BITS-1:0]     i_edge_index,
    output logic                    o_stall,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [NODE_BITS-1:0]    o_from_node,
    output logic [NODE_BITS-1:0]    o_to_node,
    output logic                    o_index_out_of_range
);

    localparam logic [CNT_BITS-1:0] NODE_MAX = CNT_BITS'(1) << NODE_BITS;

    logic [CNT_BITS-1:0]  r_node_count;
    logic                 r_directed;
    logic                 r_loops;
    t_setup               setup;
    logic [CNT_BITS-1:0]  n_sat;
    logic [CNT_BITS:0]    factor;
    logic [PROD_BITS-1:0] prod;

    logic  front_rdy, front_v, core_rdy, core_v, back_rdy;
    t_item front_item, core_item;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CNT_BITS'(2);
            r_directed   <= 1'b0;
            r_loops      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NODE_COUNT:    r_node_count <= i_cfg_data;
                CFG_DIRECTED_MODE: r_directed   <= i_cfg_data[0];
                CFG_ALLOW_LOOPS:   r_loops      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // derived settings: edge count, divisor, last vertex
    always_comb begin
        n_sat = (r_node_count > NODE_MAX) ? NODE_MAX : r_node_count;
        if (r_directed) begin
            factor = r_loops ? {1'b0, n_sat} : {1'b0, n_sat - CNT_BITS'(1)};
        end else begin
            factor = r_loops ? {1'b0, n_sat} + (CNT_BITS+1)'(1)
                             : {1'b0, n_sat - CNT_BITS'(1)};
        end
        prod = PROD_BITS'(n_sat) * PROD_BITS'(factor);
        setup.directed = r_directed;
        setup.loops    = r_loops;
        setup.div      = r_loops ? n_sat : n_sat - CNT_BITS'(1);
        setup.nm1      = NODE_BITS'(n_sat - CNT_BITS'(1));
        setup.maxe     = r_directed ? prod : (prod >> 1);
    end

    assign o_stall = !front_rdy;

    ein_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_edge_index (i_edge_index),
        .i_setup      (setup),
        .i_ready      (core_rdy),
        .o_ready      (front_rdy),
        .o_valid      (front_v),
        .o_item       (front_item)
    );

    ein_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_v),
        .i_item  (front_item),
        .i_div   (setup.div),
        .i_ready (back_rdy),
        .o_ready (core_rdy),
        .o_valid (core_v),
        .o_item  (core_item)
    );

    ein_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (core_v),
        .i_item               (core_item),
        .i_setup              (setup),
        .i_stall              (i_stall),
        .o_ready              (back_rdy),
        .o_valid              (o_valid),
        .o_from_node          (o_from_node),
        .o_to_node            (o_to_node),
        .o_index_out_of_range (o_index_out_of_range)
    );

endmodule

FILE: verif/edge_index_to_node_pair_tb.sv
// self-checking testbench for the edge index to node pair decoder
module edge_index_to_node_pair_tb;
    import ein_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD = 200;

    typedef struct {
        logic [NODE_BITS-1:0] from_node;
        logic [NODE_BITS-1:0] to_node;
        logic                 bad;
    } t_pair;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [CNT_BITS-1:0]     i_cfg_data;
    logic                    i_valid;
    logic [IDX_BITS-1:0]     i_edge_index;
    logic                    o_stall;
    logic                    o_valid;
    logic                    i_stall;
    logic [NODE_BITS-1:0]    o_from_node;
    logic [NODE_BITS-1:0]    o_to_node;
    logic                    o_index_out_of_range;

    // predictor copy of the registers
    logic [CNT_BITS-1:0] node_count_q;
    logic                directed_q;
    logic                loops_q;

    t_pair pending_pairs[$];
    int    fails;
    int    cycles;
    bit    quiet;
    bit    hold_req;

    edge_index_to_node_pair dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // node count after saturation
    function automatic longint unsigned eff_nodes();
        longint unsigned n;
        n = node_count_q;
        if (n > (64'd1 << NODE_BITS))
            n = 64'd1 << NODE_BITS;
        return n;
    endfunction

    // number of edges in the current mode
    function automatic longint unsigned edge_total();
        longint unsigned n;
        n = eff_nodes();
        if (directed_q && loops_q)
            return n * n;
        if (directed_q)
            return (n == 0) ? 0 : n * (n - 1);
        if (loops_q)
            return n * (n + 1) / 2;
        return (n == 0) ? 0 : n * (n - 1) / 2;
    endfunction

    // smallest row f with f(f+1)/2 >= s
    function automatic longint unsigned tri_root(longint unsigned s);
        longint unsigned lo, hi, mid;
        lo = 1;
        hi = 64'd1 << 18;
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (mid * (mid + 1) / 2 >= s)
                hi = mid;
            else
                lo = mid + 1;
        end
        return lo;
    endfunction

    function automatic t_pair predict_pair(logic [IDX_BITS-1:0] idx);
        longint unsigned n, s, f, fr, to;
        t_pair p;
        n = eff_nodes();
        s = idx;
        fr = 0;
        to = 0;
        p.bad = (s == 0) || (s > edge_total());
        if (!p.bad) begin
            if (directed_q && loops_q) begin
                fr = (s - 1) / n;
                to = (s - 1) % n;
            end else if (directed_q) begin
                fr = (s - 1) / (n - 1);
                to = s % (n - 1);
                if (fr == to)
                    to = n - 1;
            end else begin
                f = tri_root(s);
                fr = loops_q ? f - 1 : f;
                to = s - f * (f - 1) / 2 - 1;
            end
        end
        p.from_node = p.bad ? '0 : fr[NODE_BITS-1:0];
        p.to_node = p.bad ? '0 : to[NODE_BITS-1:0];
        return p;
    endfunction

    // send one request, with an occasional gap before it
    task automatic send_request(logic [IDX_BITS-1:0] idx);
        bit st;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_edge_index <= idx;
        forever begin
            @(negedge i_clk);
            st = o_stall;
            @(posedge i_clk);
            if (!st)
                break;
        end
        pending_pairs.push_back(predict_pair(idx));
    endtask

    // drop valid and wait until every expected result is in
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pairs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CNT_BITS-1:0] data);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_NODE_COUNT:    node_count_q = data;
            CFG_DIRECTED_MODE: directed_q = data[0];
            CFG_ALLOW_LOOPS:   loops_q = data[0];
            default: ;
        endcase
    endtask

    task automatic set_mode(logic [CNT_BITS-1:0] n, logic dir, logic lp);
        write_reg(CFG_NODE_COUNT, n);
        write_reg(CFG_DIRECTED_MODE, {16'($urandom), dir});
        write_reg(CFG_ALLOW_LOOPS, {16'($urandom), lp});
    endtask

    // index mostly inside the edge space, with edges and noise
    function automatic logic [IDX_BITS-1:0] pick_index();
        longint unsigned maxe;
        int r;
        maxe = edge_total();
        r = $urandom_range(0, 9);
        if (r == 0)
            return {1'($urandom), 32'($urandom)};
        if (r == 1)
            return '0;
        if (r == 2)
            return IDX_BITS'(maxe + $urandom_range(0, 2));
        if (maxe == 0)
            return IDX_BITS'($urandom_range(0, 3));
        return IDX_BITS'(1 + ({$urandom, $urandom} % maxe));
    endfunction

    // receiver stall bursts, long hold on request
    initial begin
        i_stall <= 1'b0;
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (quiet) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(0, 2) == 0);
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // result checker
    initial begin
        bit v, st, bad;
        logic [NODE_BITS-1:0] fr, to;
        t_pair e;
        forever begin
            @(negedge i_clk);
            v = o_valid;
            st = i_stall;
            fr = o_from_node;
            to = o_to_node;
            bad = o_index_out_of_range;
            @(posedge i_clk);
            if (i_rst_n && v && !st) begin
                if (pending_pairs.size() == 0) begin
                    $display("%0t: unexpected result from %0d to %0d flag %0b",
                             $time, fr, to, bad);
                    fails++;
                end else begin
                    e = pending_pairs.pop_front();
                    if (fr !== e.from_node) begin
                        $display("%0t: from_node expected %0d actual %0d",
                                 $time, e.from_node, fr);
                        fails++;
                    end
                    if (to !== e.to_node) begin
                        $display("%0t: to_node expected %0d actual %0d",
                                 $time, e.to_node, to);
                        fails++;
                    end
                    if (bad !== e.bad) begin
                        $display("%0t: index_out_of_range expected %0b actual %0b",
                                 $time, e.bad, bad);
                        fails++;
                    end
                end
            end
        end
    end

    // extremes of the index in every mode, small and saturated node counts
    task automatic test_directed();
        longint unsigned maxe;
        for (int m = 0; m < 4; m++) begin
            set_mode(17'h1FFFF, m[1], m[0]);
            maxe = edge_total();
            send_request('0);
            send_request(IDX_BITS'(1));
            send_request(IDX_BITS'(maxe));
            send_request(IDX_BITS'(maxe + 1));
            send_request('1);
        end
        set_mode(17'd1, 1'b0, 1'b1);
        send_request(IDX_BITS'(1));
        set_mode(17'd1, 1'b1, 1'b0);
        send_request(IDX_BITS'(1));
        set_mode(17'd0, 1'b1, 1'b1);
        send_request(IDX_BITS'(1));
        // register index past the list leaves the settings alone
        write_reg(t_cfg_reg'(2'd3), 17'd5);
        send_request(IDX_BITS'(1));
    endtask

    task automatic test_random();
        logic [CNT_BITS-1:0] n;
        for (int ph = 0; ph < 12; ph++) begin
            case ($urandom_range(0, 5))
                0: n = 17'd2;
                1: n = 17'($urandom_range(0, 1));
                2: n = ($urandom_range(0, 1) != 0) ? 17'd65536 : 17'h1FFFF;
                3: n = 17'($urandom);
                default: n = 17'($urandom_range(3, 40));
            endcase
            set_mode(n, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            for (int k = 0; k < 110; k++)
                send_request(pick_index());
        end
    endtask

    // long receiver hold while requests keep coming, then a full pause
    task automatic test_backpressure();
        set_mode(17'd37, 1'b1, 1'b0);
        hold_req = 1'b1;
        for (int k = 0; k < 60; k++)
            send_request(pick_index());
        wait_idle();
        for (int k = 0; k < 40; k++)
            send_request(pick_index());
    endtask

    task automatic test_streaming();
        quiet = 1'b1;
        set_mode(17'd1000, 1'b0, 1'b0);
        for (int k = 0; k < 120; k++)
            send_request(pick_index());
    endtask

    initial begin
        fails = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        node_count_q = 17'd2;
        directed_q = 1'b0;
        loops_q = 1'b0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_NODE_COUNT;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_edge_index <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings first
        for (int k = 0; k < 3; k++)
            send_request(IDX_BITS'(k));
        test_directed();
        test_random();
        test_backpressure();
        test_streaming();
        wait_idle();

        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
